FILE: hw/rtl/segment_result_cache_lru_macros.svh
// Assertion macros for the segment result cache.
// Included by files that carry concurrent checks; needs no other file.
`ifndef SEGMENT_RESULT_CACHE_LRU_MACROS_SVH
`define SEGMENT_RESULT_CACHE_LRU_MACROS_SVH
`ifndef SYNTH
`define SRC_ASSERT_IMP(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) \
    else $error("assertion failed");
`define SRC_ASSERT_NXT(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define SRC_ASSERT_IMP(lbl, ck, rs, a, c)
`define SRC_ASSERT_NXT(lbl, ck, rs, a, c)
`endif
`endif

FILE: hw/rtl/src_pkg.sv
// Shared constants and types for the segment result cache.
// No dependencies.
package src_pkg;
  localparam int ENTRIES_DEF    = 1024;
  localparam int STAMP_BITS_DEF = 32;
  localparam int KEY_W          = 64;
  localparam int FUNC_W         = 2;
  localparam int LAT_W          = 25;
  localparam int LON_W          = 27;
  localparam int OCC_W          = 11;
  localparam logic [OCC_W-1:0] RETAIN_RESET = 11'd820;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_FILL   = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;
endpackage

FILE: hw/rtl/src_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module src_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/src_key.sv
// Endpoint ordering and key packing for one segment.
// Depends on src_pkg.
module src_key import src_pkg::*; (
  input  logic signed [LAT_W-1:0] first_lat,
  input  logic signed [LON_W-1:0] first_lon,
  input  logic signed [LAT_W-1:0] second_lat,
  input  logic signed [LON_W-1:0] second_lon,
  output logic [KEY_W-1:0]        key
);
  logic swap;

  always_comb begin
    swap = (first_lat > second_lat) ||
           ((first_lat == second_lat) && (first_lon > second_lon));
    if (swap) begin
      key = {second_lat[15:0], second_lon[15:0], first_lat[15:0], first_lon[15:0]};
    end else begin
      key = {first_lat[15:0], first_lon[15:0], second_lat[15:0], second_lon[15:0]};
    end
  end
endmodule

FILE: hw/rtl/segment_result_cache_lru.sv
// Segment result cache: one-bit answers per segment key, LRU bulk eviction.
// Depends on src_pkg, src_key, src_ram and the assertion macro header.
//
// All entries (valid, 64-bit key, answer, use stamp) live in one RAM with a
// registered read, and every operation is a linear sweep over it. The sweep
// issues one read per cycle and compares each entry in the cycle after its
// read. A lookup miss, or a fill whose key is present, goes from the sweep
// straight to the response. A lookup hit or a fill of a new key adds a
// write-back. A fill into a full store first runs one oldest-entry sweep per
// evicted entry (ENTRIES minus retain_count, retain_count capped at
// ENTRIES-1), then a fresh lookup sweep. A clear rewrites every entry. After
// reset a clearing pass runs before the first transaction is taken; the
// configuration writes are taken at any time. One transaction is in work at
// a time; the result register lets the next transaction start while a result
// waits.
`include "segment_result_cache_lru_macros.svh"

module segment_result_cache_lru import src_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [OCC_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [FUNC_W-1:0]       func,
  input  logic signed [LAT_W-1:0] first_lat,
  input  logic signed [LON_W-1:0] first_lon,
  input  logic signed [LAT_W-1:0] second_lat,
  input  logic signed [LON_W-1:0] second_lon,
  input  logic                    answer_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    hit,
  output logic                    crosses,
  output logic [OCC_W-1:0]        occupancy,
  output logic [OCC_W-1:0]        evicted
);
  localparam int AW    = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int EW    = 1 + KEY_W + 1 + STAMP_BITS;
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  typedef enum logic [6:0] {
    ST_INIT  = 7'b0000001,  // clearing sweep (reset or clear)
    ST_IDLE  = 7'b0000010,
    ST_SCAN  = 7'b0000100,  // key search and lowest free slot
    ST_EVICT = 7'b0001000,  // oldest entry search
    ST_DROP  = 7'b0010000,  // invalidate oldest
    ST_WRITE = 7'b0100000,  // write entry back
    ST_RESP  = 7'b1000000
  } state_t;

  state_t state;

  logic [OCC_W-1:0]      retain;
  logic [STAMP_BITS-1:0] stamp_ctr;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      target;
  logic [CNT_W-1:0]      evict_cnt;
  logic                  resp_after_init;

  // captured transaction
  logic [FUNC_W-1:0]       func_r;
  logic signed [LAT_W-1:0] la1, la2;
  logic signed [LON_W-1:0] lo1, lo2;
  logic                    ans_r;
  logic [KEY_W-1:0]        key;

  // sweep pipeline
  logic [AW-1:0] iss;
  logic          iss_on;
  logic          chk_v;
  logic [AW-1:0] chk_idx;

  // sweep results
  logic                  found;
  logic [AW-1:0]         found_idx;
  logic                  found_ans;
  logic                  free_found;
  logic [AW-1:0]         free_idx;
  logic                  best_any;
  logic [AW-1:0]         best_idx;
  logic [STAMP_BITS-1:0] best_age;

  logic hit_r, cross_r;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  // RAM port signals
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] rdata;

  // combinational sweep view
  logic                  rd_v;
  logic [KEY_W-1:0]      rd_key;
  logic                  rd_ans;
  logic [STAMP_BITS-1:0] rd_age;
  logic                  found_c, free_c, best_any_c, cand;
  logic [AW-1:0]         found_idx_c, free_idx_c, best_idx_c;
  logic                  found_ans_c;
  logic [STAMP_BITS-1:0] best_age_c;
  logic                  sweep_end;
  logic [CNT_W-1:0]      tgt_c;
  logic [CNT_W-1:0]      count_dec;

  src_key u_key (
    .first_lat (la1),
    .first_lon (lo1),
    .second_lat(la2),
    .second_lon(lo2),
    .key       (key)
  );

  src_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(iss),
    .rdata(rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);

  always_comb begin
    rd_v   = rdata[EW-1];
    rd_key = rdata[EW-2 -: KEY_W];
    rd_ans = rdata[STAMP_BITS];
    rd_age = stamp_ctr - rdata[STAMP_BITS-1:0];

    found_c     = found;
    found_idx_c = found_idx;
    found_ans_c = found_ans;
    free_c      = free_found;
    free_idx_c  = free_idx;
    best_any_c  = best_any;
    best_idx_c  = best_idx;
    best_age_c  = best_age;
    cand        = 1'b0;
    if (chk_v) begin
      if (rd_v && (rd_key == key) && !found) begin
        found_c     = 1'b1;
        found_idx_c = chk_idx;
        found_ans_c = rd_ans;
      end
      if (!rd_v && !free_found) begin
        free_c     = 1'b1;
        free_idx_c = chk_idx;
      end
      // strict compare keeps the lowest index among equal ages
      cand = rd_v && (!best_any || (rd_age > best_age));
      if (cand) begin
        best_any_c = 1'b1;
        best_idx_c = chk_idx;
        best_age_c = rd_age;
      end
    end
    sweep_end = chk_v && (chk_idx == LAST);

    if (32'(retain) > 32'(ENTRIES - 1)) begin
      tgt_c = CNT_W'(ENTRIES - 1);
    end else begin
      tgt_c = CNT_W'(retain);
    end
    count_dec = count - CNT_W'(1);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_addr;
    ram_wdata = wr_data;
    case (state)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = iss;
        ram_wdata = '0;
      end
      ST_DROP: begin
        ram_we    = 1'b1;
        ram_waddr = best_idx;
        ram_wdata = '0;
      end
      ST_WRITE: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_INIT;
      retain          <= RETAIN_RESET;
      stamp_ctr       <= '0;
      count           <= '0;
      resp_after_init <= 1'b0;
      iss             <= '0;
      iss_on          <= 1'b0;
      chk_v           <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        retain <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // read pipeline bookkeeping for the sweeps
      chk_v   <= iss_on;
      chk_idx <= iss;
      if (iss_on) begin
        if (iss == LAST) begin
          iss_on <= 1'b0;
        end else begin
          iss <= iss + AW'(1);
        end
      end

      found      <= found_c;
      found_idx  <= found_idx_c;
      found_ans  <= found_ans_c;
      free_found <= free_c;
      free_idx   <= free_idx_c;
      best_any   <= best_any_c;
      best_idx   <= best_idx_c;
      best_age   <= best_age_c;

      case (state)
        ST_INIT: begin
          if (iss == LAST) begin
            iss   <= '0;
            state <= resp_after_init ? ST_RESP : ST_IDLE;
          end else begin
            iss <= iss + AW'(1);
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            func_r    <= func;
            la1       <= first_lat;
            lo1       <= first_lon;
            la2       <= second_lat;
            lo2       <= second_lon;
            ans_r     <= answer_in;
            hit_r     <= 1'b0;
            cross_r   <= 1'b0;
            evict_cnt <= '0;
            case (func)
              FUNC_LOOKUP, FUNC_FILL: begin
                iss        <= '0;
                iss_on     <= 1'b1;
                chk_v      <= 1'b0;
                found      <= 1'b0;
                free_found <= 1'b0;
                state      <= ST_SCAN;
              end
              FUNC_CLEAR: begin
                iss             <= '0;
                count           <= '0;
                resp_after_init <= 1'b1;
                state           <= ST_INIT;
              end
              default: begin
                state <= ST_RESP;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (sweep_end) begin
            if (found_c) begin
              hit_r   <= 1'b1;
              cross_r <= found_ans_c;
              if (func_r == FUNC_LOOKUP) begin
                wr_addr   <= found_idx_c;
                wr_data   <= {1'b1, key, found_ans_c, stamp_ctr};
                stamp_ctr <= stamp_ctr + STAMP_BITS'(1);
                state     <= ST_WRITE;
              end else begin
                state <= ST_RESP;
              end
            end else if (func_r == FUNC_LOOKUP) begin
              state <= ST_RESP;
            end else if (32'(count) >= 32'(ENTRIES)) begin
              target   <= tgt_c;
              iss      <= '0;
              iss_on   <= 1'b1;
              chk_v    <= 1'b0;
              best_any <= 1'b0;
              state    <= ST_EVICT;
            end else begin
              wr_addr   <= free_idx_c;
              wr_data   <= {1'b1, key, ans_r, stamp_ctr};
              stamp_ctr <= stamp_ctr + STAMP_BITS'(1);
              count     <= count + CNT_W'(1);
              state     <= ST_WRITE;
            end
          end
        end
        ST_EVICT: begin
          if (sweep_end) begin
            state <= ST_DROP;
          end
        end
        ST_DROP: begin
          count     <= count_dec;
          evict_cnt <= evict_cnt + CNT_W'(1);
          iss       <= '0;
          iss_on    <= 1'b1;
          chk_v     <= 1'b0;
          if (count_dec > target) begin
            best_any <= 1'b0;
            state    <= ST_EVICT;
          end else begin
            // rescan: key is still absent, lowest free slot is found anew
            found      <= 1'b0;
            free_found <= 1'b0;
            state      <= ST_SCAN;
          end
        end
        ST_WRITE: begin
          state <= ST_RESP;
        end
        ST_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            hit             <= hit_r;
            crosses         <= cross_r;
            occupancy       <= OCC_W'(count);
            evicted         <= OCC_W'(evict_cnt);
            resp_after_init <= 1'b0;
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `SRC_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, 32'(count) <= 32'(ENTRIES))
  `SRC_ASSERT_IMP(a_no_write_idle, clk, rst, state == ST_IDLE, !ram_we)
  `SRC_ASSERT_NXT(a_one_in_work, clk, rst, in_valid && in_ready, !in_ready)
  `SRC_ASSERT_NXT(a_drop_counts, clk, rst, state == ST_DROP,
                  count == $past(count) - CNT_W'(1))
endmodule
